### hdl/srrr_pkg.sv
// Package for the sequenced record retention ring.
// Holds sizes, command and outcome codes, controller states and item types.
// No dependencies.
package srrr_pkg;

  // slot index is the low sequence bits: keep the ring depth a power of two
  localparam int RING_DEPTH   = 8;
  localparam int CONTENT_BITS = 64;
  localparam int IDX_BITS     = $clog2(RING_DEPTH);
  localparam int HELD_BITS    = (RING_DEPTH < 8) ? RING_DEPTH : 8;

  localparam logic [31:0] U32_MAX     = 32'hFFFF_FFFF;
  localparam logic [31:0] HALF_CIRCLE = 32'h7FFF_FFFF;

  typedef enum logic [1:0] {
    FUNC_PUBLISH = 2'd0,
    FUNC_START   = 2'd1,
    FUNC_REBASE  = 2'd2,
    FUNC_STOP    = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    OUT_PUBLISHED    = 3'd0,
    OUT_DROPPED      = 3'd1,
    OUT_DUPLICATE    = 3'd2,
    OUT_SEQ_REJECT   = 3'd3,
    OUT_EXHAUSTED    = 3'd4,
    OUT_REFUSED      = 3'd5,
    OUT_CONTROL_DONE = 3'd6
  } outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_READ   = 2'd1,
    ST_APPLY  = 2'd2
  } state_t;

  typedef struct packed {
    func_t        func;
    logic [31:0]  seq_number;
    logic [31:0]  record_epoch;
    logic [15:0]  mailbox_seq;
    logic [63:0]  content_word;
  } in_item_t;

  typedef struct packed {
    logic         accepted;
    outcome_t     outcome;
    logic         lane_active;
    logic [31:0]  cur_epoch;
    logic [31:0]  newest_sequence;
    logic [15:0]  newest_mailbox_seq;
    logic [7:0]   held_mask;
    logic [31:0]  published_total;
    logic [31:0]  duplicate_total;
    logic [31:0]  reject_total;
    logic [31:0]  overwrite_total;
    logic [31:0]  gap_total;
  } result_t;

  typedef struct packed {
    logic capture;
    logic apply;
  } ctrl_cmd_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] c);
    sat_inc = (c == U32_MAX) ? c : c + 32'd1;
  endfunction

endpackage

### hdl/srrr_ram.sv
// Generic RAM with one write port and one registered read port.
// Depends on nothing.
module srrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/srrr_ctrl.sv
// Controller for the retention ring: sequences capture, slot read and apply.
// Depends on srrr_pkg.
module srrr_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  output srrr_pkg::ctrl_cmd_t    cmd
);

  srrr_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srrr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      srrr_pkg::ST_IDLE: begin
        if (start) begin
          state_next = srrr_pkg::ST_READ;
        end
      end
      srrr_pkg::ST_READ:  state_next = srrr_pkg::ST_APPLY;
      srrr_pkg::ST_APPLY: state_next = srrr_pkg::ST_IDLE;
      default:            state_next = srrr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      srrr_pkg::ST_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      srrr_pkg::ST_READ:   cmd       = '0;
      srrr_pkg::ST_APPLY:  cmd.apply = 1'b1;
      default:             busy      = 1'b1;
    endcase
  end

endmodule

### hdl/srrr_datapath.sv
// Datapath for the retention ring: item capture, slot index,
// serial-order decision, lane state, counters and result register.
// Depends on srrr_pkg and srrr_ram.
module srrr_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  srrr_pkg::ctrl_cmd_t    cmd,
  input  srrr_pkg::in_item_t     item,
  output logic                   done,
  output srrr_pkg::result_t      result
);

  // captured item
  srrr_pkg::func_t                   func;
  logic [31:0]                       seq;
  logic [31:0]                       ep;
  logic [15:0]                       mbox;
  logic [srrr_pkg::CONTENT_BITS-1:0] content;
  logic [31:0]                       adv;
  logic [31:0]                       gapm1;
  logic                              wrap;
  logic [srrr_pkg::IDX_BITS-1:0]     idx;

  // lane state
  logic                              active;
  logic [31:0]                       epoch;
  logic [srrr_pkg::RING_DEPTH-1:0]   retained;
  logic [31:0]                       latest_seq;
  logic [15:0]                       latest_mbox;
  logic [31:0]                       publish_ctr;
  logic [31:0]                       duplicate_ctr;
  logic [31:0]                       reject_ctr;
  logic [31:0]                       overwrite_ctr;
  logic [31:0]                       gap_ctr;

  logic                              active_next;
  logic [31:0]                       epoch_next;
  logic [srrr_pkg::RING_DEPTH-1:0]   retained_next;
  logic [31:0]                       latest_seq_next;
  logic [15:0]                       latest_mbox_next;
  logic [31:0]                       publish_ctr_next;
  logic [31:0]                       duplicate_ctr_next;
  logic [31:0]                       reject_ctr_next;
  logic [31:0]                       overwrite_ctr_next;
  logic [31:0]                       gap_ctr_next;
  srrr_pkg::outcome_t                outcome;
  logic                              slot_we;

  logic [srrr_pkg::CONTENT_BITS-1:0] slot_rdata;
  logic                              held;
  logic [srrr_pkg::RING_DEPTH-1:0]   slot_bit;
  logic [srrr_pkg::RING_DEPTH-1:0]   bits_after;
  logic [32:0]                       gap_sum;

  srrr_ram #(
    .WIDTH(srrr_pkg::CONTENT_BITS),
    .DEPTH(srrr_pkg::RING_DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (slot_we),
    .waddr (idx),
    .wdata (content),
    .raddr (idx),
    .rdata (slot_rdata)
  );

  // capture item and take the slot index from the low sequence bits
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func    <= item.func;
      seq     <= item.seq_number;
      ep      <= item.record_epoch;
      mbox    <= item.mailbox_seq;
      content <= item.content_word[srrr_pkg::CONTENT_BITS-1:0];
      adv     <= item.seq_number - latest_seq;
      gapm1   <= item.seq_number - latest_seq - 32'd1;
      wrap    <= item.seq_number < latest_seq;
      idx     <= item.seq_number[srrr_pkg::IDX_BITS-1:0];
    end
  end

  assign held     = (retained != '0);
  assign slot_bit = srrr_pkg::RING_DEPTH'(1) << idx;
  assign gap_sum  = {1'b0, gap_ctr} + {1'b0, gapm1};

  always_comb begin
    active_next        = active;
    epoch_next         = epoch;
    retained_next      = retained;
    latest_seq_next    = latest_seq;
    latest_mbox_next   = latest_mbox;
    publish_ctr_next   = publish_ctr;
    duplicate_ctr_next = duplicate_ctr;
    reject_ctr_next    = reject_ctr;
    overwrite_ctr_next = overwrite_ctr;
    gap_ctr_next       = gap_ctr;
    outcome            = srrr_pkg::OUT_CONTROL_DONE;
    slot_we            = 1'b0;
    bits_after         = retained;
    case (func)
      srrr_pkg::FUNC_PUBLISH: begin
        if (!active || ep != epoch) begin
          outcome = srrr_pkg::OUT_DROPPED;
        end else if (held && (adv == '0 || adv > srrr_pkg::HALF_CIRCLE)) begin
          if (adv == '0 && slot_rdata == content) begin
            duplicate_ctr_next = srrr_pkg::sat_inc(duplicate_ctr);
            outcome            = srrr_pkg::OUT_DUPLICATE;
          end else begin
            reject_ctr_next = srrr_pkg::sat_inc(reject_ctr);
            outcome         = srrr_pkg::OUT_SEQ_REJECT;
          end
        end else if (held && wrap && epoch == srrr_pkg::U32_MAX) begin
          reject_ctr_next = srrr_pkg::sat_inc(reject_ctr);
          active_next     = 1'b0;
          outcome         = srrr_pkg::OUT_EXHAUSTED;
        end else begin
          if (held && wrap) begin
            epoch_next = epoch + 32'd1;
            bits_after = '0;
          end
          if ((bits_after & slot_bit) != '0) begin
            overwrite_ctr_next = srrr_pkg::sat_inc(overwrite_ctr);
          end
          if (held && adv > 32'd1) begin
            gap_ctr_next = gap_sum[32] ? srrr_pkg::U32_MAX : gap_sum[31:0];
          end
          slot_we          = 1'b1;
          retained_next    = bits_after | slot_bit;
          latest_seq_next  = seq;
          latest_mbox_next = mbox;
          publish_ctr_next = srrr_pkg::sat_inc(publish_ctr);
          outcome          = srrr_pkg::OUT_PUBLISHED;
        end
      end
      srrr_pkg::FUNC_STOP: begin
        active_next = 1'b0;
      end
      default: begin
        if (epoch == srrr_pkg::U32_MAX) begin
          outcome = srrr_pkg::OUT_REFUSED;
        end else begin
          epoch_next       = epoch + 32'd1;
          retained_next    = '0;
          latest_seq_next  = '0;
          latest_mbox_next = '0;
          if (func == srrr_pkg::FUNC_START) begin
            active_next        = 1'b1;
            publish_ctr_next   = '0;
            duplicate_ctr_next = '0;
            reject_ctr_next    = '0;
            overwrite_ctr_next = '0;
            gap_ctr_next       = '0;
          end
        end
      end
    endcase
    if (!cmd.apply) begin
      slot_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active        <= 1'b0;
      epoch         <= '0;
      retained      <= '0;
      latest_seq    <= '0;
      latest_mbox   <= '0;
      publish_ctr   <= '0;
      duplicate_ctr <= '0;
      reject_ctr    <= '0;
      overwrite_ctr <= '0;
      gap_ctr       <= '0;
      done          <= 1'b0;
    end else begin
      done <= cmd.apply;
      if (cmd.apply) begin
        active        <= active_next;
        epoch         <= epoch_next;
        retained      <= retained_next;
        latest_seq    <= latest_seq_next;
        latest_mbox   <= latest_mbox_next;
        publish_ctr   <= publish_ctr_next;
        duplicate_ctr <= duplicate_ctr_next;
        reject_ctr    <= reject_ctr_next;
        overwrite_ctr <= overwrite_ctr_next;
        gap_ctr       <= gap_ctr_next;
      end
    end
  end

  // hold the result for the strobe cycle
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      result.accepted           <= (outcome == srrr_pkg::OUT_PUBLISHED) ||
                                   (outcome == srrr_pkg::OUT_CONTROL_DONE);
      result.outcome            <= outcome;
      result.lane_active        <= active_next;
      result.cur_epoch          <= epoch_next;
      result.newest_sequence    <= latest_seq_next;
      result.newest_mailbox_seq <= latest_mbox_next;
      result.held_mask          <= 8'(retained_next[srrr_pkg::HELD_BITS-1:0]);
      result.published_total    <= publish_ctr_next;
      result.duplicate_total    <= duplicate_ctr_next;
      result.reject_total       <= reject_ctr_next;
      result.overwrite_total    <= overwrite_ctr_next;
      result.gap_total          <= gap_ctr_next;
    end
  end

endmodule

### hdl/sequenced_record_retention_ring.sv
// Sequenced record retention ring: serial-number ordered record ring.
// Sequence: the item is captured when accepted, its slot is read in ST_READ and
// the result is registered in ST_APPLY; busy drops with the result strobe.
// A new item is taken only after busy drops, so items never overlap.
// Synchronous reset clears lane state and counters; results cannot be stalled.
module sequenced_record_retention_ring (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  srrr_pkg::in_item_t  item,
  output logic                done,
  output srrr_pkg::result_t   result
);

  srrr_pkg::ctrl_cmd_t  cmd;

  srrr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd)
  );

  srrr_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .item   (item),
    .done   (done),
    .result (result)
  );

`ifndef SYNTH
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe lasted more than one cycle");

  a_accepted_code: assert property (@(posedge clk) disable iff (rst)
    done |-> result.accepted == ((result.outcome == srrr_pkg::OUT_PUBLISHED) ||
                                 (result.outcome == srrr_pkg::OUT_CONTROL_DONE)))
    else $error("accepted flag disagrees with outcome");

  a_exhausted_stops: assert property (@(posedge clk) disable iff (rst)
    done && result.outcome == srrr_pkg::OUT_EXHAUSTED |-> !result.lane_active)
    else $error("exhausted lane still active");
`endif

endmodule

### dv/sequenced_record_retention_ring_test.sv
// Self-checking test for the sequenced record retention ring.
// Drives start/busy items, predicts every result and compares it field by field.
// Depends on srrr_pkg and the sequenced_record_retention_ring top level.
module sequenced_record_retention_ring_test;

  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_ITEMS = 460;

  typedef struct {
    srrr_pkg::func_t func;
    bit              seq_rel;
    logic [31:0]     seq;
    bit              ep_rel;
    logic [31:0]     ep;
    logic [15:0]     mbox;
    bit              same_content;
    logic [63:0]     content;
    bit              drain;
  } cmd_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  srrr_pkg::in_item_t item = '0;
  logic done;
  srrr_pkg::result_t result;

  sequenced_record_retention_ring u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
  );

  logic                              lane_on = 1'b0;
  logic [31:0]                       lane_epoch = '0;
  logic [31:0]                       ring_held = '0;
  logic [31:0]                       newest_seq = '0;
  logic [15:0]                       newest_mbox = '0;
  logic [srrr_pkg::CONTENT_BITS-1:0] slot_word [srrr_pkg::RING_DEPTH];
  logic [31:0]                       cnt_pub = '0;
  logic [31:0]                       cnt_dup = '0;
  logic [31:0]                       cnt_rej = '0;
  logic [31:0]                       cnt_ovw = '0;
  logic [31:0]                       cnt_gap = '0;

  cmd_t              cmd_queue[$];
  srrr_pkg::result_t owed_results[$];
  int                mismatches = 0;
  int                items_sent = 0;
  int                results_seen = 0;
  int                wrap_count = 0;
  int                drain_pauses = 0;
  int                outcome_tally[8];
  int                gap_left = 0;
  int                stall_cycles = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [31:0] plus_one_sat(logic [31:0] c);
    return (c == srrr_pkg::U32_MAX) ? c : c + 32'd1;
  endfunction

  task automatic advance_ring(input srrr_pkg::in_item_t it, output srrr_pkg::result_t r);
    logic [srrr_pkg::IDX_BITS-1:0] idx;
    logic                          held;
    logic [31:0]                   adv;
    logic [31:0]                   skipped;
    srrr_pkg::outcome_t            oc;
    idx = srrr_pkg::IDX_BITS'(it.seq_number % srrr_pkg::RING_DEPTH);
    held = ring_held != 0;
    adv = it.seq_number - newest_seq;
    oc = srrr_pkg::OUT_CONTROL_DONE;
    case (it.func)
      srrr_pkg::FUNC_PUBLISH: begin
        if (!lane_on || it.record_epoch != lane_epoch) begin
          oc = srrr_pkg::OUT_DROPPED;
        end else if (held && (adv == 0 || adv > srrr_pkg::HALF_CIRCLE)) begin
          if (adv == 0 &&
              slot_word[idx] == it.content_word[srrr_pkg::CONTENT_BITS-1:0]) begin
            cnt_dup = plus_one_sat(cnt_dup);
            oc = srrr_pkg::OUT_DUPLICATE;
          end else begin
            cnt_rej = plus_one_sat(cnt_rej);
            oc = srrr_pkg::OUT_SEQ_REJECT;
          end
        end else if (held && it.seq_number < newest_seq &&
                     lane_epoch == srrr_pkg::U32_MAX) begin
          cnt_rej = plus_one_sat(cnt_rej);
          lane_on = 1'b0;
          oc = srrr_pkg::OUT_EXHAUSTED;
        end else begin
          if (held && it.seq_number < newest_seq) begin
            lane_epoch = lane_epoch + 32'd1;
            ring_held = '0;
            wrap_count++;
          end
          if (ring_held[idx]) cnt_ovw = plus_one_sat(cnt_ovw);
          if (held && adv > 32'd1) begin
            skipped = adv - 32'd1;
            cnt_gap = (srrr_pkg::U32_MAX - cnt_gap < skipped) ? srrr_pkg::U32_MAX :
                      cnt_gap + skipped;
          end
          slot_word[idx] = it.content_word[srrr_pkg::CONTENT_BITS-1:0];
          ring_held[idx] = 1'b1;
          newest_seq = it.seq_number;
          newest_mbox = it.mailbox_seq;
          cnt_pub = plus_one_sat(cnt_pub);
          oc = srrr_pkg::OUT_PUBLISHED;
        end
      end
      srrr_pkg::FUNC_STOP: begin
        lane_on = 1'b0;
      end
      default: begin
        if (lane_epoch == srrr_pkg::U32_MAX) begin
          oc = srrr_pkg::OUT_REFUSED;
        end else begin
          lane_epoch = lane_epoch + 32'd1;
          ring_held = '0;
          newest_seq = '0;
          newest_mbox = '0;
          if (it.func == srrr_pkg::FUNC_START) begin
            lane_on = 1'b1;
            cnt_pub = '0;
            cnt_dup = '0;
            cnt_rej = '0;
            cnt_ovw = '0;
            cnt_gap = '0;
          end
        end
      end
    endcase
    r.accepted = (oc == srrr_pkg::OUT_PUBLISHED || oc == srrr_pkg::OUT_CONTROL_DONE);
    r.outcome = oc;
    r.lane_active = lane_on;
    r.cur_epoch = lane_epoch;
    r.newest_sequence = newest_seq;
    r.newest_mailbox_seq = newest_mbox;
    r.held_mask = ring_held[7:0];
    r.published_total = cnt_pub;
    r.duplicate_total = cnt_dup;
    r.reject_total = cnt_rej;
    r.overwrite_total = cnt_ovw;
    r.gap_total = cnt_gap;
  endtask

  // Relative fields resolve against the predicted state at the moment the item goes out.
  function automatic srrr_pkg::in_item_t shape_item(cmd_t c);
    srrr_pkg::in_item_t it;
    it.func = c.func;
    it.seq_number = c.seq_rel ? newest_seq + c.seq : c.seq;
    it.record_epoch = c.ep_rel ? lane_epoch + c.ep : c.ep;
    it.mailbox_seq = c.mbox;
    if (c.same_content && ring_held != 0)
      it.content_word = 64'(slot_word[newest_seq % srrr_pkg::RING_DEPTH]);
    else
      it.content_word = c.content;
    return it;
  endfunction

  function automatic cmd_t mk_ctl(srrr_pkg::func_t f);
    cmd_t c;
    c.func = f;
    c.seq_rel = 1'b0;
    c.seq = $urandom;
    c.ep_rel = 1'b0;
    c.ep = $urandom;
    c.mbox = 16'($urandom);
    c.same_content = 1'b0;
    c.content = {$urandom, $urandom};
    c.drain = 1'b0;
    return c;
  endfunction

  function automatic cmd_t mk_pub(logic [31:0] seq, bit rel);
    cmd_t c;
    c = mk_ctl(srrr_pkg::FUNC_PUBLISH);
    c.seq_rel = rel;
    c.seq = seq;
    c.ep_rel = 1'b1;
    c.ep = '0;
    return c;
  endfunction

  task automatic check_field(string name, logic [63:0] want_v, logic [63:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : drive
    srrr_pkg::result_t owed;
    cmd_t              nx;
    logic              took;
    if (rst) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      took = start && !busy;
      if (took) begin
        advance_ring(item, owed);
        owed_results.push_back(owed);
        items_sent++;
      end
      if (start && !took) begin
        // hold the item until busy drops
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (cmd_queue.size() == 0) begin
        start <= 1'b0;
      end else if (cmd_queue[0].drain && owed_results.size() != 0) begin
        start <= 1'b0;
      end else if (!(items_sent >= 200 && items_sent < 350) && $urandom_range(0, 99) < 7) begin
        gap_left = $urandom_range(0, 5);
        start <= 1'b0;
      end else begin
        nx = cmd_queue.pop_front();
        if (nx.drain) drain_pauses++;
        item <= shape_item(nx);
        start <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : watch
    srrr_pkg::result_t want;
    if (!rst && done) begin
      results_seen++;
      if (owed_results.size() == 0) begin
        $error("result strobe with no item outstanding");
        mismatches++;
      end else begin
        want = owed_results.pop_front();
        outcome_tally[want.outcome]++;
        check_field("accepted", 64'(want.accepted), 64'(result.accepted));
        check_field("outcome", 64'(want.outcome), 64'(result.outcome));
        check_field("lane_active", 64'(want.lane_active), 64'(result.lane_active));
        check_field("cur_epoch", 64'(want.cur_epoch), 64'(result.cur_epoch));
        check_field("newest_sequence", 64'(want.newest_sequence),
                    64'(result.newest_sequence));
        check_field("newest_mailbox_seq", 64'(want.newest_mailbox_seq),
                    64'(result.newest_mailbox_seq));
        check_field("held_mask", 64'(want.held_mask), 64'(result.held_mask));
        check_field("published_total", 64'(want.published_total),
                    64'(result.published_total));
        check_field("duplicate_total", 64'(want.duplicate_total),
                    64'(result.duplicate_total));
        check_field("reject_total", 64'(want.reject_total), 64'(result.reject_total));
        check_field("overwrite_total", 64'(want.overwrite_total),
                    64'(result.overwrite_total));
        check_field("gap_total", 64'(want.gap_total), 64'(result.gap_total));
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    cmd_t c;
    int   roll;
    int   pick;
    int   hop;
    for (int i = 0; i < srrr_pkg::RING_DEPTH; i++) slot_word[i] = '0;
    for (int i = 0; i < 8; i++) outcome_tally[i] = 0;

    c = mk_pub(32'hFFFF_FFFF, 1'b0);
    c.ep_rel = 1'b0;
    c.ep = 32'hFFFF_FFFF;
    c.mbox = 16'hFFFF;
    c.content = '1;
    cmd_queue.push_back(c);
    cmd_queue.push_back(mk_ctl(srrr_pkg::FUNC_STOP));
    cmd_queue.push_back(mk_ctl(srrr_pkg::FUNC_START));
    c = mk_pub(32'd0, 1'b0);
    c.ep = 32'd1;
    cmd_queue.push_back(c);
    c = mk_pub(32'd0, 1'b0);
    c.mbox = '0;
    c.content = '0;
    cmd_queue.push_back(c);
    c = mk_pub(32'd0, 1'b1);
    c.same_content = 1'b1;
    cmd_queue.push_back(c);
    cmd_queue.push_back(mk_pub(32'd0, 1'b1));
    cmd_queue.push_back(mk_pub(32'd1, 1'b1));
    cmd_queue.push_back(mk_pub(32'd5, 1'b1));
    cmd_queue.push_back(mk_pub(32'hFFFF_FFFF, 1'b1));
    cmd_queue.push_back(mk_pub(32'h8000_0000, 1'b1));
    cmd_queue.push_back(mk_pub(32'd8, 1'b1));
    cmd_queue.push_back(mk_pub(srrr_pkg::HALF_CIRCLE, 1'b1));
    cmd_queue.push_back(mk_pub(srrr_pkg::HALF_CIRCLE, 1'b1));
    cmd_queue.push_back(mk_pub(32'd1, 1'b1));
    c = mk_ctl(srrr_pkg::FUNC_REBASE);
    c.drain = 1'b1;
    cmd_queue.push_back(c);
    cmd_queue.push_back(mk_pub(32'hFFFF_FFFE, 1'b0));
    cmd_queue.push_back(mk_pub(32'd1, 1'b1));
    cmd_queue.push_back(mk_pub(32'd1, 1'b1));
    cmd_queue.push_back(mk_ctl(srrr_pkg::FUNC_STOP));
    cmd_queue.push_back(mk_pub(32'd1, 1'b1));
    cmd_queue.push_back(mk_ctl(srrr_pkg::FUNC_START));
    c = mk_pub(32'hFFFF_FFFF, 1'b0);
    c.mbox = 16'hFFFF;
    c.content = '1;
    cmd_queue.push_back(c);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 85) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) c = mk_pub(32'd1, 1'b1);
        else if (pick < 70) c = mk_pub($urandom_range(2, 9), 1'b1);
        else if (pick < 76) begin
          c = mk_pub(32'd0, 1'b1);
          c.same_content = 1'b1;
        end
        else if (pick < 80) c = mk_pub(32'd0, 1'b1);
        else if (pick < 85) c = mk_pub(-$urandom_range(1, 20), 1'b1);
        else if (pick < 88)
          c = mk_pub($urandom_range(srrr_pkg::HALF_CIRCLE - 15, srrr_pkg::HALF_CIRCLE), 1'b1);
        else if (pick < 90) c = mk_pub(32'h8000_0000 + $urandom_range(0, 15), 1'b1);
        else if (pick < 95) c = mk_pub($urandom, 1'b0);
        else c = mk_pub($urandom_range(srrr_pkg::U32_MAX - 15, srrr_pkg::U32_MAX), 1'b0);
        hop = $urandom_range(0, 99);
        if (hop < 4) c.ep = 32'd1;
        else if (hop < 6) c.ep = 32'hFFFF_FFFF;
        else if (hop < 9) begin
          c.ep_rel = 1'b0;
          c.ep = $urandom;
        end
      end else if (roll < 90) begin
        c = mk_ctl(srrr_pkg::FUNC_REBASE);
      end else if (roll < 94) begin
        c = mk_ctl(srrr_pkg::FUNC_START);
      end else if (roll < 97) begin
        cmd_queue.push_back(mk_ctl(srrr_pkg::FUNC_STOP));
        repeat ($urandom_range(0, 3)) cmd_queue.push_back(mk_pub(32'd1, 1'b1));
        c = mk_ctl(srrr_pkg::FUNC_START);
      end else begin
        c = mk_ctl(srrr_pkg::func_t'($urandom_range(0, 3)));
      end
      if ($urandom_range(0, 99) < 2) c.drain = 1'b1;
      cmd_queue.push_back(c);
      if ((c.func == srrr_pkg::FUNC_START || c.func == srrr_pkg::FUNC_REBASE) &&
          $urandom_range(0, 1))
        cmd_queue.push_back(mk_pub($urandom_range(srrr_pkg::U32_MAX - 6, srrr_pkg::U32_MAX),
                                   1'b0));
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (cmd_queue.size() != 0 || start || owed_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (owed_results.size() != 0) begin
      $error("%0d results never arrived", owed_results.size());
      mismatches++;
    end

    $display("Run: %0d items, %0d results; published %0d, dropped %0d, duplicate %0d",
             items_sent, results_seen, outcome_tally[srrr_pkg::OUT_PUBLISHED],
             outcome_tally[srrr_pkg::OUT_DROPPED], outcome_tally[srrr_pkg::OUT_DUPLICATE]);
    $display("Sequence rejects %0d, control %0d, namespace wraps %0d, drain pauses %0d",
             outcome_tally[srrr_pkg::OUT_SEQ_REJECT],
             outcome_tally[srrr_pkg::OUT_CONTROL_DONE], wrap_count, drain_pauses);
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
